FILE: rtl/core/hsl2rgb_pkg.sv
// hsl2rgb_pkg: shared widths, sector codes and stage-boundary struct
// for the hsl to rgb color converter
// no dependencies
package hsl2rgb_pkg;

    localparam int FIELD_W = 17;
    localparam int HI_W    = FIELD_W + 1;
    localparam int H6_W    = FIELD_W + 3;
    localparam int TDATA_W = ((3 * FIELD_W + 7) / 8) * 8;
    localparam int SEC_W   = 3;

    localparam logic [SEC_W-1:0] SEC_0 = 3'd0;
    localparam logic [SEC_W-1:0] SEC_1 = 3'd1;
    localparam logic [SEC_W-1:0] SEC_2 = 3'd2;
    localparam logic [SEC_W-1:0] SEC_3 = 3'd3;
    localparam logic [SEC_W-1:0] SEC_4 = 3'd4;
    localparam logic [SEC_W-1:0] SEC_5 = 3'd5;

    typedef struct packed {
        logic [HI_W-1:0] hi;
        logic [HI_W-1:0] lo;
        logic [H6_W-1:0] h6;
    } t_ext;

endpackage

FILE: rtl/core/hsl2rgb_extent.sv
// hsl2rgb_extent: four pipeline stages that saturate the inputs and
// compute the high and low channel values and six times the hue
// depends on hsl2rgb_pkg
module hsl2rgb_extent #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [hsl2rgb_pkg::FIELD_W-1:0]     i_hue,
    input  logic [hsl2rgb_pkg::FIELD_W-1:0]     i_lightness,
    input  logic [hsl2rgb_pkg::FIELD_W-1:0]     i_saturation,
    output logic                                o_valid,
    input  logic                                i_ready,
    output hsl2rgb_pkg::t_ext                   o_ext
);
    import hsl2rgb_pkg::*;

    localparam int CMPW = (FRAC_BITS + 1 > FIELD_W) ? FRAC_BITS + 1 : FIELD_W;
    localparam int AW   = CMPW + 1;
    localparam int PW   = AW + FIELD_W;
    localparam logic [CMPW-1:0] ONE_C  = CMPW'(1) << FRAC_BITS;
    localparam logic [CMPW-1:0] HALF_C = ONE_C >> 1;

    logic                 r_v1, r_v2, r_v3, r_v4;
    logic                 w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    logic [FIELD_W-1:0]   r_h1, r_l1, r_s1;
    logic [PW-1:0]        r_prod2;
    logic [FIELD_W-1:0]   r_s2, r_l2;
    logic                 r_upper2;
    logic [H6_W-1:0]      r_h62;
    logic [HI_W-1:0]      r_hi3, r_l2x3;
    logic [H6_W-1:0]      r_h63;
    t_ext                 r_ext4;

    logic [FIELD_W-1:0]   n_h1, n_l1, n_s1;
    logic [AW-1:0]        n_mul_a;
    logic [PW-1:0]        n_prod2;
    logic                 n_upper2;
    logic [H6_W-1:0]      n_h62;
    logic [PW-1:0]        n_prod_sh;
    logic [HI_W-1:0]      n_hi3;
    logic [HI_W-1:0]      n_lo4;

    function automatic logic [FIELD_W-1:0] sat_one(input logic [FIELD_W-1:0] x);
        logic [CMPW-1:0] xc;
        xc = CMPW'(x);
        sat_one = (xc > ONE_C) ? FIELD_W'(ONE_C) : x;
    endfunction

    assign w_rdy4  = !r_v4 || i_ready;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v4;
    assign o_ext   = r_ext4;

    // stage 1: saturate to one
    assign n_h1 = sat_one(i_hue);
    assign n_l1 = sat_one(i_lightness);
    assign n_s1 = sat_one(i_saturation);

    // stage 2: high-value product and hue times six
    always_comb begin
        n_upper2 = CMPW'(r_l1) > HALF_C;
        if (n_upper2) begin
            n_mul_a = AW'(ONE_C - CMPW'(r_s1));
        end else begin
            n_mul_a = AW'(ONE_C) + AW'(r_s1);
        end
        n_prod2 = PW'(n_mul_a) * PW'(r_l1);
        n_h62   = (H6_W'(r_h1) << 2) + (H6_W'(r_h1) << 1);
    end

    // stage 3: high value
    always_comb begin
        n_prod_sh = r_prod2 >> FRAC_BITS;
        n_hi3     = HI_W'(n_prod_sh) + (r_upper2 ? HI_W'(r_s2) : HI_W'(0));
    end

    // stage 4: low value clamped to 0..hi
    always_comb begin
        if (r_l2x3 >= r_hi3) begin
            n_lo4 = r_l2x3 - r_hi3;
        end else begin
            n_lo4 = '0;
        end
        if (n_lo4 > r_hi3) begin
            n_lo4 = r_hi3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_h1 <= n_h1;
            r_l1 <= n_l1;
            r_s1 <= n_s1;
        end
        if (w_rdy2 && r_v1) begin
            r_prod2  <= n_prod2;
            r_s2     <= r_s1;
            r_l2     <= r_l1;
            r_upper2 <= n_upper2;
            r_h62    <= n_h62;
        end
        if (w_rdy3 && r_v2) begin
            r_hi3  <= n_hi3;
            r_l2x3 <= {r_l2, 1'b0};
            r_h63  <= r_h62;
        end
        if (w_rdy4 && r_v3) begin
            r_ext4.hi <= r_hi3;
            r_ext4.lo <= n_lo4;
            r_ext4.h6 <= r_h63;
        end
    end

    a_sat_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (CMPW'(r_h1) <= ONE_C && CMPW'(r_l1) <= ONE_C && CMPW'(r_s1) <= ONE_C))
        else $error("saturated input above one");

    a_lo_le_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> r_ext4.lo <= r_ext4.hi)
        else $error("low value above high value");

endmodule

FILE: rtl/core/hsl2rgb_blend.sv
// hsl2rgb_blend: two pipeline stages that form the hue step and route
// high, low, rise and fall onto the three channels by sector
// depends on hsl2rgb_pkg
module hsl2rgb_blend #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  hsl2rgb_pkg::t_ext                   i_ext,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [hsl2rgb_pkg::FIELD_W-1:0]     o_red,
    output logic [hsl2rgb_pkg::FIELD_W-1:0]     o_blue,
    output logic [hsl2rgb_pkg::FIELD_W-1:0]     o_green
);
    import hsl2rgb_pkg::*;

    localparam int XW = ((FRAC_BITS + 1 > FIELD_W) ? FRAC_BITS + 1 : FIELD_W) + 3;
    localparam int PW = FRAC_BITS + HI_W;

    logic                 r_v5, r_v6;
    logic                 w_rdy5, w_rdy6;

    logic [PW-1:0]        r_prod5;
    logic [HI_W-1:0]      r_hi5, r_lo5;
    logic [SEC_W-1:0]     r_idx5;
    logic [FIELD_W-1:0]   r_red6, r_blue6, r_green6;

    logic [XW-1:0]        n_h6x;
    logic [XW-1:0]        n_idx_full;
    logic [SEC_W-1:0]     n_idx5;
    logic [FRAC_BITS-1:0] n_frac5;
    logic [PW-1:0]        n_prod5;
    logic [PW-1:0]        n_step_full;
    logic [HI_W-1:0]      n_step, n_rise, n_fall;
    logic [HI_W-1:0]      n_red, n_blue, n_green;

    assign w_rdy6  = !r_v6 || i_ready;
    assign w_rdy5  = !r_v5 || w_rdy6;
    assign o_ready = w_rdy5;
    assign o_valid = r_v6;
    assign o_red   = r_red6;
    assign o_blue  = r_blue6;
    assign o_green = r_green6;

    // stage 5: sector, fraction and step product
    always_comb begin
        n_h6x      = XW'(i_ext.h6);
        n_idx_full = n_h6x >> FRAC_BITS;
        n_frac5    = n_h6x[FRAC_BITS-1:0];
        // hue of exactly one folds into the last sector
        if (n_idx_full > XW'(SEC_5)) begin
            n_idx5 = SEC_5;
        end else begin
            n_idx5 = n_idx_full[SEC_W-1:0];
        end
        n_prod5 = PW'(n_frac5) * PW'(i_ext.hi - i_ext.lo);
    end

    // stage 6: rise, fall and channel routing
    always_comb begin
        n_step_full = r_prod5 >> FRAC_BITS;
        n_step      = n_step_full[HI_W-1:0];
        n_rise      = r_lo5 + n_step;
        n_fall      = r_hi5 - n_step;
        case (r_idx5)
            SEC_0: begin
                n_red = r_hi5;  n_blue = n_rise; n_green = r_lo5;
            end
            SEC_1: begin
                n_red = n_fall; n_blue = r_hi5;  n_green = r_lo5;
            end
            SEC_2: begin
                n_red = r_lo5;  n_blue = r_hi5;  n_green = n_rise;
            end
            SEC_3: begin
                n_red = r_lo5;  n_blue = n_fall; n_green = r_hi5;
            end
            SEC_4: begin
                n_red = n_rise; n_blue = r_lo5;  n_green = r_hi5;
            end
            default: begin
                n_red = r_hi5;  n_blue = r_lo5;  n_green = n_fall;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (w_rdy5) begin
                r_v5 <= i_valid;
            end
            if (w_rdy6) begin
                r_v6 <= r_v5;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy5 && i_valid) begin
            r_prod5 <= n_prod5;
            r_hi5   <= i_ext.hi;
            r_lo5   <= i_ext.lo;
            r_idx5  <= n_idx5;
        end
        if (w_rdy6 && r_v5) begin
            r_red6   <= n_red[FIELD_W-1:0];
            r_blue6  <= n_blue[FIELD_W-1:0];
            r_green6 <= n_green[FIELD_W-1:0];
        end
    end

    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |-> n_step <= (r_hi5 - r_lo5))
        else $error("step exceeds high minus low");

    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |-> r_idx5 <= SEC_5)
        else $error("sector out of range");

endmodule

FILE: rtl/core/hsl_to_rgb_color_convert.sv
// hsl_to_rgb_color_convert: top level of the hsl to rgb converter
// depends on hsl2rgb_pkg, hsl2rgb_extent, hsl2rgb_blend
// an accepted input word passes through the hsl2rgb_extent stages, then the hsl2rgb_blend stages
// throughput: one word per cycle; stalls back up stage by stage, bubbles close
// reset: synchronous active low i_rst_n clears all stage valid bits
// no configuration; the pipeline accepts words right after reset
module hsl_to_rgb_color_convert #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // hue [16:0], lightness [33:17], saturation [50:34], zero [55:51]
    input  logic [hsl2rgb_pkg::TDATA_W-1:0]     i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // red_out [16:0], blue_out [33:17], green_out [50:34], zero [55:51]
    output logic [hsl2rgb_pkg::TDATA_W-1:0]     o_m_axis_tdata
);
    import hsl2rgb_pkg::*;

    localparam int PAD_W = TDATA_W - 3 * FIELD_W;

    logic               w_ext_valid, w_ext_ready;
    t_ext               w_ext;
    logic [FIELD_W-1:0] w_red, w_blue, w_green;

    hsl2rgb_extent #(
        .FRAC_BITS (FRAC_BITS)
    ) u_extent (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_hue        (i_s_axis_tdata[FIELD_W-1:0]),
        .i_lightness  (i_s_axis_tdata[2*FIELD_W-1:FIELD_W]),
        .i_saturation (i_s_axis_tdata[3*FIELD_W-1:2*FIELD_W]),
        .o_valid      (w_ext_valid),
        .i_ready      (w_ext_ready),
        .o_ext        (w_ext)
    );

    hsl2rgb_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_ext_valid),
        .o_ready (w_ext_ready),
        .i_ext   (w_ext),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_red   (w_red),
        .o_blue  (w_blue),
        .o_green (w_green)
    );

    assign o_m_axis_tdata = {PAD_W'(0), w_green, w_blue, w_red};

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready && w_ext_valid))
        else $error("input blocked while pipeline has room");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_axis_tvalid && !w_ext_valid))
        else $error("valid word after reset");

endmodule

FILE: verif/tb_top.sv
// tb_top: self-checking stream testbench for hsl_to_rgb_color_convert
// predicts each output word from its hsl input word and checks it field by field
// depends on hsl2rgb_pkg and the hsl_to_rgb_color_convert rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hsl2rgb_pkg::*;

    localparam int          FRAC_BITS   = 16;
    localparam logic [63:0] UNIT        = 64'd1 << FRAC_BITS;
    localparam int          RAND_WORDS  = 1130;
    localparam int          CALM_FROM   = 500;
    localparam int          CALM_TO     = 800;
    localparam int          HOLD_AT     = 300;
    localparam int          HOLD_LEN    = 300;
    localparam int          QUIET_LIMIT = 3000;

    typedef struct packed {
        logic [FIELD_W-1:0] saturation;
        logic [FIELD_W-1:0] lightness;
        logic [FIELD_W-1:0] hue;
    } t_hsl;

    typedef struct packed {
        logic [FIELD_W-1:0] green_out;
        logic [FIELD_W-1:0] blue_out;
        logic [FIELD_W-1:0] red_out;
    } t_rgb;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    // hue, lightness, saturation, zero fill
    logic [TDATA_W-1:0] i_s_axis_tdata = '0;
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    // red_out, blue_out, green_out, zero fill
    logic [TDATA_W-1:0] o_m_axis_tdata;

    t_hsl hsl_pending[$];
    t_rgb rgb_expected[$];
    t_hsl px_on_bus;
    int   words_in = 0;
    int   words_out = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;
    int   quiet_cycles = 0;
    int   err_count = 0;

    hsl_to_rgb_color_convert #(
        .FRAC_BITS(FRAC_BITS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] clamp_unit(logic [FIELD_W-1:0] x);
        return (64'(x) > UNIT) ? UNIT : 64'(x);
    endfunction

    function automatic t_rgb predict_rgb(t_hsl px);
        logic [63:0] h, l, s, hi, lo, h6, sector, frac, step, rise, fall;
        t_rgb        res;
        h = clamp_unit(px.hue);
        l = clamp_unit(px.lightness);
        s = clamp_unit(px.saturation);
        res = '0;
        if (l > (UNIT >> 1)) begin
            hi = (((UNIT - s) * l) >> FRAC_BITS) + s;
        end else begin
            hi = ((s + UNIT) * l) >> FRAC_BITS;
        end
        if (hi == 0) begin
            return res;
        end
        lo = (2 * l >= hi) ? 2 * l - hi : 64'd0;
        if (lo > hi) begin
            lo = hi;
        end
        h6 = h * 6;
        sector = h6 >> FRAC_BITS;
        frac = h6 & (UNIT - 1);
        // hue of exactly one lands in sector six, folded into five
        if (sector > 5) begin
            sector = 5;
        end
        step = (frac * (hi - lo)) >> FRAC_BITS;
        rise = lo + step;
        fall = hi - step;
        case (sector[SEC_W-1:0])
            SEC_0: begin
                res.red_out = hi[FIELD_W-1:0];   res.blue_out = rise[FIELD_W-1:0];
                res.green_out = lo[FIELD_W-1:0];
            end
            SEC_1: begin
                res.red_out = fall[FIELD_W-1:0]; res.blue_out = hi[FIELD_W-1:0];
                res.green_out = lo[FIELD_W-1:0];
            end
            SEC_2: begin
                res.red_out = lo[FIELD_W-1:0];   res.blue_out = hi[FIELD_W-1:0];
                res.green_out = rise[FIELD_W-1:0];
            end
            SEC_3: begin
                res.red_out = lo[FIELD_W-1:0];   res.blue_out = fall[FIELD_W-1:0];
                res.green_out = hi[FIELD_W-1:0];
            end
            SEC_4: begin
                res.red_out = rise[FIELD_W-1:0]; res.blue_out = lo[FIELD_W-1:0];
                res.green_out = hi[FIELD_W-1:0];
            end
            default: begin
                res.red_out = hi[FIELD_W-1:0];   res.blue_out = lo[FIELD_W-1:0];
                res.green_out = fall[FIELD_W-1:0];
            end
        endcase
        return res;
    endfunction

    function automatic logic [FIELD_W-1:0] pick_component();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            return FIELD_W'($urandom_range(0, (1 << FIELD_W) - 1));
        end else if (roll < 14) begin
            return FIELD_W'(UNIT);
        end else if (roll < 17) begin
            return '0;
        end
        return FIELD_W'($urandom_range(0, 32'(UNIT)));
    endfunction

    function automatic t_hsl make_px(int h, int l, int s);
        t_hsl px;
        px.hue = FIELD_W'(h);
        px.lightness = FIELD_W'(l);
        px.saturation = FIELD_W'(s);
        return px;
    endfunction

    task automatic check_field(string name, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        bit idle;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                rgb_expected.push_back(predict_rgb(px_on_bus));
                words_in++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                idle = !(words_in >= CALM_FROM && words_in < CALM_TO)
                       && ($urandom_range(0, 99) < 6);
                if (hsl_pending.size() != 0 && !idle) begin
                    px_on_bus = hsl_pending.pop_front();
                    i_s_axis_tdata <= TDATA_W'(px_on_bus);
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_rgb want;
        t_rgb got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            words_out++;
            got = t_rgb'(o_m_axis_tdata[3*FIELD_W-1:0]);
            if (rgb_expected.size() == 0) begin
                $error("unexpected output word: red %0d blue %0d green %0d",
                       got.red_out, got.blue_out, got.green_out);
                err_count++;
            end else begin
                want = rgb_expected.pop_front();
                check_field("red_out", want.red_out, got.red_out);
                check_field("blue_out", want.blue_out, got.blue_out);
                check_field("green_out", want.green_out, got.green_out);
            end
        end
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (!hold_done && words_out >= HOLD_AT) begin
            // long back-pressure so the pipeline fills and stalls its input
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= (words_out >= CALM_FROM && words_out < CALM_TO)
                               || ($urandom_range(0, 99) >= 6);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("timeout: no word moved in %0d cycles", QUIET_LIMIT);
                    $display("end of test: mismatches");
                    $finish;
                end
            end
        end
    end

    initial begin
        // dark, over-range and full-scale corners
        hsl_pending.push_back(make_px(0, 0, 0));
        hsl_pending.push_back(make_px(0, 0, 65536));
        hsl_pending.push_back(make_px(131071, 131071, 131071));
        hsl_pending.push_back(make_px(65536, 65536, 65536));
        hsl_pending.push_back(make_px(65536, 32768, 65536));
        hsl_pending.push_back(make_px(65537, 40000, 50000));
        hsl_pending.push_back(make_px(1, 1, 1));
        // one pixel per sector on each side of half lightness
        for (int k = 0; k < 6; k++) begin
            hsl_pending.push_back(make_px(k * 10923 + 3000, 30000, 50000));
            hsl_pending.push_back(make_px(k * 10923 + 7000, 50000, 40000));
        end
        hsl_pending.push_back(make_px(20000, 32768, 30000));
        hsl_pending.push_back(make_px(20000, 32769, 30000));
        hsl_pending.push_back(make_px(45000, 40000, 0));
        hsl_pending.push_back(make_px(12000, 131071, 5000));
        hsl_pending.push_back(make_px(32'h15555, 32'h0AAAA, 32'h15555));
        hsl_pending.push_back(make_px(32'h0AAAA, 32'h15555, 32'h0AAAA));
        hsl_pending.push_back(make_px(65535, 65535, 65535));
        for (int n = 0; n < RAND_WORDS; n++) begin
            hsl_pending.push_back(make_px(pick_component(), pick_component(), pick_component()));
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (hsl_pending.size() != 0 || i_s_axis_tvalid || rgb_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
